// File: src/cse_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and polynomial tables for the Chebyshev series evaluator.
// No dependencies; every other file in src imports this package.
package cse_pkg;

   // fixed-point layout
   localparam int TFRAC   = 26;  // fraction bits of t, t*t and Horner partials
   localparam int OFRAC   = 24;  // fraction bits of the series sum
   localparam int TW      = 28;  // t and t*t, range [-1, 1] in Q.26
   localparam int HW      = 36;  // Horner partials, up to about 112 in Q.26
   localparam int XW      = 32;  // sample and range_low
   localparam int CW      = 32;  // one coefficient, Q8.24
   localparam int SW      = 48;  // series value, Q24.24
   localparam int NUM_COEF  = 7;
   localparam int NUM_TERMS = 4; // Horner terms per polynomial, leading zeros padded

   // configuration port
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;

   // register indexes, byte address is 8 * index
   localparam logic [2:0] REG_RANGE_LOW   = 3'd0;
   localparam logic [2:0] REG_RANGE_SCALE = 3'd1;
   localparam logic [2:0] REG_COEF_12     = 3'd2;
   localparam logic [2:0] REG_COEF_34     = 3'd3;
   localparam logic [2:0] REG_COEF_56     = 3'd4;
   localparam logic [2:0] REG_COEF_7      = 3'd5;

   typedef logic signed [TW-1:0] tval_type;
   typedef logic signed [HW-1:0] hval_type;
   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef struct packed {
      logic signed [XW-1:0]     range_low;
      logic [31:0]              range_scale;
      coef_type [NUM_COEF:1]    coef;
   } cfg_type;

   // T_k in powers of t*t (odd k still need one more multiply by t).
   // Shorter polynomials get leading zeros: a zero partial rounds to zero exactly.
   localparam int POLY_C [2:7][0:NUM_TERMS-1] = '{
      '{  0,    0,   2,  -1 },
      '{  0,    0,   4,  -3 },
      '{  0,    8,  -8,   1 },
      '{  0,   16, -20,   5 },
      '{ 32,  -48,  18,  -1 },
      '{ 64, -112,  56,  -7 }
   };

   localparam tval_type T_ONE   = TW'(1) << TFRAC;
   localparam sum_type  SUM_ONE = SW'(1) << OFRAC;

   // small integer times one in Q.26
   function automatic hval_type tone_mult(input int c);
      return HW'(c) <<< TFRAC;
   endfunction

endpackage

// File: src/chebyshev_series_evaluator_core.sv
`timescale 1ns / 1ps
// Chebyshev series evaluator (first kind, degree up to 7), top level.
// Uses cse_pkg, cse_csr, cse_norm and cse_cell.
//
//   port group | role         | beat contents
//   -----------+--------------+----------------------------------------------
//   req_*      | stream in    | tdata[31:0] sample (Q16.16)
//   rsp_*      | stream out   | tdata[47:0] series_value (Q24.24), tuser[0] out_of_range
//   csr_*      | APB config   | 64-bit data, register i at byte 8*i
//
// Throughput is one beat per cycle while rsp_tready stays high. The pipeline is the
// chain of cells: 3 normalization stages, one squaring cell, three Horner cells,
// one basis stage (odd terms times t), then one accumulate cell per coefficient.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage moves forward when it is empty or its neighbor moves, so bubbles close
// up and input beats are taken while a result waits on rsp_tready, until all stages fill.
module chebyshev_series_evaluator_core #(
   parameter int MAX_DEGREE = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // [31:0] sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata,   // [47:0] series_value
   output logic [0:0]                   rsp_tuser,   // [0] out_of_range
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cse_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [cse_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [cse_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import cse_pkg::*;

   localparam int ST_T2   = 3;               // squaring cell
   localparam int ST_BAS  = 7;               // basis cells
   localparam int STAGES  = ST_BAS + 1 + MAX_DEGREE;

   cfg_type               cfg;
   logic [STAGES-1:0]     vld_ff, vld_in;
   logic [STAGES:0]       en;
   tval_type              t_n;
   logic                  flag_n;
   logic [STAGES-1:3]     flag_ff;
   tval_type              t_ff [3:6];
   tval_type              t2_sq;
   tval_type              t2_ff [4:5];
   tval_type              t2_step [1:3];
   hval_type              hrn [2:7][1:3];
   hval_type              bas0 [1:7];
   hval_type              bas_ff [1:MAX_DEGREE][1:7];
   sum_type               acc [0:MAX_DEGREE];

   // configuration registers
   cse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage enables: a stage loads when empty or when its successor loads
   assign en[STAGES] = rsp_tready;
   for (genvar s = 0; s < STAGES; s++) begin : g_en
      assign en[s] = !vld_ff[s] || en[s+1];
   end

   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s] = en[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];

   // normalization, stages 0 to 2
   cse_norm u_norm (
      .clock       (clock),
      .en          (en[2:0]),
      .sample      (req_tdata),
      .range_low   (cfg.range_low),
      .range_scale (cfg.range_scale),
      .t_ff        (t_n),
      .flag_ff     (flag_n)
   );

   // flag rides along to the output
   always_ff @(posedge clock) begin
      if (en[3]) begin
         flag_ff[3] <= flag_n;
      end
   end
   for (genvar s = 4; s < STAGES; s++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en[s]) begin
            flag_ff[s] <= flag_ff[s-1];
         end
      end
   end

   // t and t*t delay taps
   always_ff @(posedge clock) begin
      if (en[3]) begin
         t_ff[3] <= t_n;
      end
      if (en[4]) begin
         t_ff[4]  <= t_ff[3];
         t2_ff[4] <= t2_sq;
      end
      if (en[5]) begin
         t_ff[5]  <= t_ff[4];
         t2_ff[5] <= t2_ff[4];
      end
      if (en[6]) begin
         t_ff[6] <= t_ff[5];
      end
   end

   assign t2_step[1] = t2_sq;
   assign t2_step[2] = t2_ff[4];
   assign t2_step[3] = t2_ff[5];

   // squaring cell
   cse_cell #(.AW(TW), .BW(TW), .OW(TW)) u_sq (
      .clock  (clock),
      .en     (en[ST_T2]),
      .op_a   (t_n),
      .op_b   (t_n),
      .addend ('0),
      .res_ff (t2_sq)
   );

   // Horner cells, one row of three per polynomial
   for (genvar k = 2; k <= MAX_DEGREE; k++) begin : g_poly
      for (genvar s = 1; s < NUM_TERMS; s++) begin : g_step
         if (s == 1) begin : g_first
            cse_cell #(.AW(HW), .BW(TW), .OW(HW)) u_hrn (
               .clock  (clock),
               .en     (en[ST_T2+s]),
               .op_a   (tone_mult(POLY_C[k][0])),
               .op_b   (t2_step[s]),
               .addend (tone_mult(POLY_C[k][s])),
               .res_ff (hrn[k][s])
            );
         end else begin : g_next
            cse_cell #(.AW(HW), .BW(TW), .OW(HW)) u_hrn (
               .clock  (clock),
               .en     (en[ST_T2+s]),
               .op_a   (hrn[k][s-1]),
               .op_b   (t2_step[s]),
               .addend (tone_mult(POLY_C[k][s])),
               .res_ff (hrn[k][s])
            );
         end
      end
   end

   // basis cells: T1 = t, odd terms times t, even terms times one
   cse_cell #(.AW(HW), .BW(TW), .OW(HW)) u_bas1 (
      .clock  (clock),
      .en     (en[ST_BAS]),
      .op_a   (HW'(t_ff[6])),
      .op_b   (T_ONE),
      .addend ('0),
      .res_ff (bas0[1])
   );
   for (genvar k = 2; k <= MAX_DEGREE; k++) begin : g_bas
      cse_cell #(.AW(HW), .BW(TW), .OW(HW)) u_bas (
         .clock  (clock),
         .en     (en[ST_BAS]),
         .op_a   (hrn[k][NUM_TERMS-1]),
         .op_b   ((k % 2 == 1) ? t_ff[6] : T_ONE),
         .addend ('0),
         .res_ff (bas0[k])
      );
   end

   // basis values wait for their accumulate cell
   for (genvar j = 1; j < MAX_DEGREE; j++) begin : g_bdly
      for (genvar k = j + 1; k <= MAX_DEGREE; k++) begin : g_bk
         always_ff @(posedge clock) begin
            if (en[ST_BAS+j]) begin
               if (j == 1) begin
                  bas_ff[j][k] <= bas0[k];
               end else begin
                  bas_ff[j][k] <= bas_ff[j-1][k];
               end
            end
         end
      end
   end

   // accumulate chain, one coefficient per cell
   assign acc[0] = SUM_ONE;
   for (genvar j = 1; j <= MAX_DEGREE; j++) begin : g_acc
      if (j == 1) begin : g_head
         cse_cell #(.AW(CW), .BW(HW), .OW(SW)) u_acc (
            .clock  (clock),
            .en     (en[ST_BAS+j]),
            .op_a   (cfg.coef[j]),
            .op_b   (bas0[j]),
            .addend (acc[j-1]),
            .res_ff (acc[j])
         );
      end else begin : g_tail
         cse_cell #(.AW(CW), .BW(HW), .OW(SW)) u_acc (
            .clock  (clock),
            .en     (en[ST_BAS+j]),
            .op_a   (cfg.coef[j]),
            .op_b   (bas_ff[j-1][j]),
            .addend (acc[j-1]),
            .res_ff (acc[j])
         );
      end
   end

   // result beat
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = acc[MAX_DEGREE];
   assign rsp_tuser  = flag_ff[STAGES-1];

   // checks
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_clamp_ends: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && flag_n |-> (t_n == T_ONE || t_n == -T_ONE))
      else $error("flagged sample not clamped to an end of the range");

   a_square_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_T2] |-> (!t2_sq[TW-1] && t2_sq <= T_ONE))
      else $error("t squared outside [0, 1]");

endmodule

// File: src/cse_cell.sv
`timescale 1ns / 1ps
// One cell of the evaluation chain: registered addend + round(a * b / 2^26).
// Depends on cse_pkg for the fraction width.
module cse_cell #(
   parameter int AW = 36,
   parameter int BW = 28,
   parameter int OW = 36
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] op_a,
   input  logic signed [BW-1:0] op_b,
   input  logic signed [OW-1:0] addend,
   output logic signed [OW-1:0] res_ff
);
   import cse_pkg::*;

   localparam int PW = AW + BW + 1;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (TFRAC - 1);

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rnd;
   logic signed [PW-1:0] shf;
   logic signed [OW-1:0] res_in;

   // multiply, round to nearest with ties up, add the neighbor's value
   always_comb begin
      prod   = PW'(op_a) * PW'(op_b);
      rnd    = prod + HALF;
      shf    = rnd >>> TFRAC;
      res_in = addend + OW'(shf);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule

// File: src/cse_norm.sv
`timescale 1ns / 1ps
// Sample normalization: t = (x - range_low) * range_scale - 1, clamped to [-1, 1].
// Three pipeline stages; depends on cse_pkg.
module cse_norm (
   input  logic                      clock,
   input  logic [2:0]                en,
   input  logic signed [31:0]        sample,
   input  logic signed [31:0]        range_low,
   input  logic [31:0]               range_scale,
   output cse_pkg::tval_type         t_ff,
   output logic                      flag_ff
);
   import cse_pkg::*;

   localparam logic [63:0] U_TWO  = 64'(1) << 41;
   localparam logic [41:0] U_HALF = 42'(1) << 13;

   logic signed [32:0] d_ff, d_in;
   logic [63:0]        u_ff, u_in;
   logic               neg_ff, nz_ff;
   logic [41:0]        u_sum;
   tval_type           t_calc, t_in;
   logic               flag_in;

   // stage 0: exact 33-bit difference
   assign d_in = 33'(sample) - 33'(range_low);

   // stage 1: Q.40 product, valid when the difference is not negative
   assign u_in = 64'(d_ff[31:0]) * 64'(range_scale);

   // stage 2: round to Q.26 and clamp
   always_comb begin
      u_sum  = u_ff[41:0] + U_HALF;
      t_calc = TW'(u_sum >> 14) - T_ONE;
      if (neg_ff) begin
         t_in    = -T_ONE;
         flag_in = nz_ff;
      end else if (u_ff > U_TWO) begin
         t_in    = T_ONE;
         flag_in = 1'b1;
      end else begin
         t_in    = t_calc;
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d_ff <= d_in;
      end
      if (en[1]) begin
         u_ff   <= u_in;
         neg_ff <= d_ff[32];
         nz_ff  <= |range_scale;
      end
      if (en[2]) begin
         t_ff    <= t_in;
         flag_ff <= flag_in;
      end
   end

endmodule

// File: src/cse_csr.sv
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port, 64-bit data, 8-byte stride.
// Depends on cse_pkg for the configuration struct.
module cse_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cse_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [cse_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [cse_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output cse_pkg::cfg_type             cfg
);
   import cse_pkg::*;

   logic [31:0] low_ff, scale_ff, c7_ff;
   logic [63:0] c12_ff, c34_ff, c56_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= 32'hFFFF_0000;
         scale_ff <= 32'h0100_0000;
         c12_ff   <= '0;
         c34_ff   <= '0;
         c56_ff   <= '0;
         c7_ff    <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_RANGE_LOW:   low_ff   <= csr_pwdata[31:0];
            REG_RANGE_SCALE: scale_ff <= csr_pwdata[31:0];
            REG_COEF_12:     c12_ff   <= csr_pwdata;
            REG_COEF_34:     c34_ff   <= csr_pwdata;
            REG_COEF_56:     c56_ff   <= csr_pwdata;
            REG_COEF_7:      c7_ff    <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_RANGE_LOW:   csr_prdata = {32'b0, low_ff};
         REG_RANGE_SCALE: csr_prdata = {32'b0, scale_ff};
         REG_COEF_12:     csr_prdata = c12_ff;
         REG_COEF_34:     csr_prdata = c34_ff;
         REG_COEF_56:     csr_prdata = c56_ff;
         REG_COEF_7:      csr_prdata = {32'b0, c7_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // unpack into the datapath view
   always_comb begin
      cfg.range_low   = low_ff;
      cfg.range_scale = scale_ff;
      cfg.coef[1]     = c12_ff[31:0];
      cfg.coef[2]     = c12_ff[63:32];
      cfg.coef[3]     = c34_ff[31:0];
      cfg.coef[4]     = c34_ff[63:32];
      cfg.coef[5]     = c56_ff[31:0];
      cfg.coef[6]     = c56_ff[63:32];
      cfg.coef[7]     = c7_ff;
   end

endmodule

// File: tb/chebyshev_series_evaluator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for chebyshev_series_evaluator_core: streams samples in,
// programs the range and coefficient registers over APB, predicts every series value.
// Depends on cse_pkg and the evaluator RTL.
module chebyshev_series_evaluator_core_tb;
   import cse_pkg::*;

   localparam int MAX_DEGREE    = 7;
   localparam int LATENCY       = 8 + MAX_DEGREE;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 92;
   localparam int REPORT_LIMIT  = 10;

   // unmapped register slots, byte address is 8 * index
   localparam int REG_UNMAPPED        = 6;
   localparam int REG_SLOTS           = 8;

   // t, t*t and Horner partials in Q.26
   localparam int     FRAC_T = 26;
   localparam longint ONE_T  = longint'(1) << FRAC_T;

   typedef logic [cse_pkg::ADDR_W-1:0] csr_addr_type;

   typedef struct packed {
      logic [47:0] value;
      logic        clamped;
   } series_beat_type;

   // Predicts one series beat per accepted sample and checks result beats in order
   class series_scoreboard;
      logic signed [31:0] range_low;
      logic [31:0]        range_scale;
      logic signed [31:0] coef [1:7];
      series_beat_type    expected_series [$];
      int                 errors;

      function new();
         errors = 0;
         range_low   = 32'hFFFF_0000;
         range_scale = 32'h0100_0000;
         for (int k = 1; k <= 7; k++) coef[k] = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [63:0] data);
         case (idx)
            REG_RANGE_LOW:   range_low   = data[31:0];
            REG_RANGE_SCALE: range_scale = data[31:0];
            REG_COEF_12:     begin coef[1] = data[31:0]; coef[2] = data[63:32]; end
            REG_COEF_34:     begin coef[3] = data[31:0]; coef[4] = data[63:32]; end
            REG_COEF_56:     begin coef[5] = data[31:0]; coef[6] = data[63:32]; end
            REG_COEF_7:      coef[7] = data[31:0];
            default: ;
         endcase
      endfunction

      // round to nearest Q.26, ties toward plus infinity
      function longint round_q26(longint v);
         return (v + (longint'(1) << (FRAC_T - 1))) >>> FRAC_T;
      endfunction

      function longint mul_q26(longint a, longint b);
         return round_q26(a * b);
      endfunction

      // power form in t*t, leading zeros for shorter polynomials
      function longint horner4(int c0, int c1, int c2, int c3, longint t2);
         longint p;
         p = longint'(c0) * ONE_T;
         p = mul_q26(p, t2) + longint'(c1) * ONE_T;
         p = mul_q26(p, t2) + longint'(c2) * ONE_T;
         p = mul_q26(p, t2) + longint'(c3) * ONE_T;
         return p;
      endfunction

      function series_beat_type series_of_sample(logic signed [31:0] x);
         longint          d, t, t2, acc;
         longint          basis [1:7];
         logic [63:0]     u;
         series_beat_type beat;
         beat.clamped = 1'b0;
         d = longint'(x) - longint'(range_low);
         if (d < 0) begin
            // below range, flag only when the scale is nonzero
            t = -ONE_T;
            beat.clamped = (range_scale != 0);
         end else begin
            u = 64'(d) * {32'b0, range_scale};
            if (u > (64'd1 << 41)) begin
               t = ONE_T;
               beat.clamped = 1'b1;
            end else begin
               t = longint'((u + 64'd8192) >> 14) - ONE_T;
            end
         end
         t2 = mul_q26(t, t);
         basis[1] = t;
         basis[2] = horner4(0, 0, 2, -1, t2);
         basis[3] = mul_q26(t, horner4(0, 0, 4, -3, t2));
         basis[4] = horner4(0, 8, -8, 1, t2);
         basis[5] = mul_q26(t, horner4(0, 16, -20, 5, t2));
         basis[6] = horner4(32, -48, 18, -1, t2);
         basis[7] = mul_q26(t, horner4(64, -112, 56, -7, t2));
         acc = longint'(1) << 24;
         for (int k = 1; k <= MAX_DEGREE; k++)
            acc += round_q26(longint'(coef[k]) * basis[k]);
         beat.value = acc[47:0];
         return beat;
      endfunction

      function void note_sample(logic [31:0] x);
         expected_series.push_back(series_of_sample(x));
      endfunction

      function void check_result(logic [47:0] value, logic clamped);
         series_beat_type want;
         if (expected_series.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result beat: value %h clamped %b", value, clamped);
            return;
         end
         want = expected_series.pop_front();
         if (want.value !== value || want.clamped !== clamped) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("mismatch: expected value %h clamped %b, got value %h clamped %b",
                        want.value, want.clamped, value, clamped);
         end
      endfunction

      function int pending();
         return expected_series.size();
      endfunction
   endclass

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata   = '0;   // [31:0] sample
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [47:0]                  rsp_tdata;          // [47:0] series_value
   logic [0:0]                   rsp_tuser;          // [0] out_of_range
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [cse_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [cse_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [cse_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   series_scoreboard series_check;
   bit               no_idle     = 1'b0;
   int               cycle_count = 0;

   chebyshev_series_evaluator_core #(
      .MAX_DEGREE (MAX_DEGREE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         series_check.check_result(rsp_tdata, rsp_tuser[0]);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one sample beat, entered and left at a falling edge
   task automatic send_sample(input logic [31:0] x);
      while (!no_idle && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      series_check.note_sample(x);
      @(negedge clock);
   endtask

   // APB write: setup phase, access phase, then back to idle
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= csr_addr_type'({idx, 3'b000});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      series_check.set_reg(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (series_check.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coef();
      logic signed [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0;
         default: return c >>> $urandom_range(0, 8);
      endcase
   endfunction

   // mostly samples inside the programmed range, the rest anywhere
   function automatic logic [31:0] pick_sample();
      logic [63:0] span, offset;
      if ($urandom_range(0, 99) < 25) return $urandom;
      if ($urandom_range(0, 99) < 4) return series_check.range_low;
      if (series_check.range_scale == 0)
         span = 64'hFFFF_FFFF;
      else
         span = (64'd1 << 41) / {32'b0, series_check.range_scale};
      offset = {$urandom, $urandom} % (span + 64'd1);
      return series_check.range_low + offset[31:0];
   endfunction

   task automatic random_config();
      logic [31:0] low, scale;
      case ($urandom_range(0, 9))
         0:       low = 32'h8000_0000;
         1:       low = 32'h7FFF_FFFF;
         2:       low = 32'hFFFF_0000;
         default: low = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       scale = 32'h0;
         1:       scale = 32'hFFFF_FFFF;
         default: scale = $urandom >> $urandom_range(0, 22);
      endcase
      csr_write(REG_RANGE_LOW, {$urandom, low});
      csr_write(REG_RANGE_SCALE, {$urandom, scale});
      csr_write(REG_COEF_12, {pick_coef(), pick_coef()});
      csr_write(REG_COEF_34, {pick_coef(), pick_coef()});
      csr_write(REG_COEF_56, {pick_coef(), pick_coef()});
      csr_write(REG_COEF_7, {32'h0, pick_coef()});
   endtask

   initial begin
      series_check = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: t equals x, all coefficients zero
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_0000);   // exact low end
      send_sample(32'h0001_0000);   // exact high end
      send_sample(32'h8000_0000);   // below range
      send_sample(32'h7FFF_FFFF);   // above range
      drain_results();

      // every term active, extreme coefficients included
      csr_write(REG_COEF_12, 64'hFF80_0000_0100_0000);
      csr_write(REG_COEF_34, 64'h8000_0000_7FFF_FFFF);
      csr_write(REG_COEF_56, 64'hFFC0_0000_0040_0000);
      csr_write(REG_COEF_7,  64'h0000_0000_0020_0000);
      send_sample(32'hFFFF_0000);
      send_sample(32'h0001_0000);
      send_sample(32'h0000_0000);
      send_sample(32'h0000_8000);
      send_sample(32'hFFFF_8000);
      send_sample(32'h0001_0001);   // just above range
      send_sample(32'hFFFE_FFFF);   // just below range
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      drain_results();

      // zero scale: t pinned low, flag stays clear
      csr_write(REG_RANGE_SCALE, 64'h0);
      send_sample(32'h1234_5678);
      send_sample(32'h8000_0000);
      send_sample(32'hFFFF_0000);
      drain_results();

      // widest operands, writes to unmapped slots must change nothing
      csr_write(REG_RANGE_LOW, 64'h8000_0000);
      csr_write(REG_RANGE_SCALE, 64'hFFFF_FFFF);
      for (int r = REG_UNMAPPED; r < REG_SLOTS; r++) csr_write(3'(r), {$urandom, $urandom});
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0001);
      send_sample(32'h7FFF_FFFF);
      drain_results();
      csr_write(REG_RANGE_LOW, 64'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0000);
      drain_results();

      // random phases, each with its own register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config();
         no_idle = (p == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == PHASE_ITEMS / 2) drain_results();
            send_sample(pick_sample());
         end
         drain_results();
      end
      no_idle = 1'b0;

      repeat (4 * LATENCY) @(posedge clock);
      if (series_check.errors == 0 && series_check.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
src/cse_pkg.sv
src/cse_cell.sv
src/cse_norm.sv
src/cse_csr.sv
src/chebyshev_series_evaluator_core.sv
tb/chebyshev_series_evaluator_core_tb.sv
